// ----- sv/gingerbread_chaos_oscillator_assert.svh -----
// Assertion macros for the gingerbread chaos oscillator.
// Used by the top level; no other dependencies. Define SYNTH to drop the checks.
`ifndef GINGERBREAD_CHAOS_OSCILLATOR_ASSERT_SVH
`define GINGERBREAD_CHAOS_OSCILLATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define GCO_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication, disabled during reset
`define GCO_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define GCO_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define GCO_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

// ----- sv/gco_pkg.sv -----
// Shared types and constants for the gingerbread chaos oscillator.
// No dependencies; imported by every module of the block.
package gco_pkg;

    localparam int CHANNELS = 8;
    localparam int CHAN_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int FREQ_W  = 19;
    localparam int RATE_W  = 32;
    localparam int STEP_W  = 34;  // clamped step, [-2^32, 2^32]
    localparam int PHASE_W = 35;  // phase in units of 2^-32, inside (-1, 2)
    localparam int Y_W     = 32;  // map value, Q8.24
    localparam int PROD_W  = 62;  // y times gain, magnitude below 2^61

    localparam logic signed [PHASE_W-1:0] PHASE_ONE = 35'sd4294967296;
    localparam logic signed [Y_W-1:0]     GAIN_Q32  = 32'sd781684048;  // 0.182
    localparam logic signed [Y_W-1:0]     OFFSET_Q24 = 32'sd7633633;   // 0.455

    localparam logic [RATE_W-1:0]     RATE_RECIP_RST   = 32'd89478;
    localparam logic signed [Y_W-1:0] INIT_Y_PREV_RST  = 32'sd20132659;  // 1.2
    localparam logic signed [Y_W-1:0] INIT_Y_PREV2_RST = 32'sd35232154;  // 2.1

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RATE_RECIP   = 2'd0,
        CFG_INIT_Y_PREV  = 2'd1,
        CFG_INIT_Y_PREV2 = 2'd2
    } gco_cfg_t;

    // Item after the step multiply
    typedef struct packed {
        logic [CHAN_W-1:0]        ch;
        logic                     neg;
        logic                     reload;
        logic signed [STEP_W-1:0] step;
    } gco_s0_t;

    // Item after the channel state update
    typedef struct packed {
        logic [CHAN_W-1:0]     ch;
        logic                  trig;
        logic signed [Y_W-1:0] y;
    } gco_s1_t;

endpackage

// ----- sv/gco_step.sv -----
// Input stage: registers an item and its clamped phase step.
// Depends on gco_pkg.
module gco_step
    import gco_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [2:0]               channel,
    input  logic signed [FREQ_W-1:0] frequency,
    input  logic                     reload,
    input  logic [RATE_W-1:0]        rate_recip,
    input  logic                     dn_ready,
    output logic                     up_ready,
    output logic                     s0_valid,
    output gco_s0_t                  s0
);

    localparam int MUL_W = FREQ_W + RATE_W + 1;
    localparam logic signed [MUL_W-1:0] MUL_MAX = 52'sd4294967296;
    localparam logic signed [MUL_W-1:0] MUL_MIN = -52'sd4294967296;

    logic                     valid_reg;
    gco_s0_t                  data_reg;
    gco_s0_t                  data_next;
    logic signed [MUL_W-1:0]  mul;
    logic                     chan_ok;

    // Scale frequency to a phase step and clamp to one period either way
    always_comb
    begin
        mul     = $signed(frequency) * $signed({1'b0, rate_recip});
        chan_ok = int'(channel) < CHANNELS;
        data_next.ch     = channel[CHAN_W-1:0];
        data_next.neg    = frequency[FREQ_W-1];
        data_next.reload = reload;
        if (mul > MUL_MAX)
        begin
            data_next.step = STEP_W'(MUL_MAX);
        end
        else if (mul < MUL_MIN)
        begin
            data_next.step = STEP_W'(MUL_MIN);
        end
        else
        begin
            data_next.step = mul[STEP_W-1:0];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    // Hold the valid flag; drop items for channels that do not exist
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= in_valid && chan_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign s0_valid = valid_reg;
    assign s0       = data_reg;

endmodule

// ----- sv/gco_chan.sv -----
// Channel state stage: phase accumulators and map history per channel.
// Depends on gco_pkg.
module gco_chan
    import gco_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s0_valid,
    input  gco_s0_t               s0,
    input  logic signed [Y_W-1:0] init_y_prev,
    input  logic signed [Y_W-1:0] init_y_prev2,
    input  logic                  dn_ready,
    output logic                  up_ready,
    output logic                  s1_valid,
    output gco_s1_t               s1
);

    localparam int SUM_W = Y_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_ONE = 34'sd16777216;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -34'sd2147483648;

    logic signed [PHASE_W-1:0] phase_reg [CHANNELS];
    logic signed [Y_W-1:0]     y1_reg    [CHANNELS];
    logic signed [Y_W-1:0]     y2_reg    [CHANNELS];

    logic                      valid_reg;
    gco_s1_t                   data_reg;
    gco_s1_t                   data_next;

    logic                      take;
    logic signed [PHASE_W-1:0] phase_rd;
    logic signed [PHASE_W-1:0] phase_wrap;
    logic signed [PHASE_W-1:0] phase_next;
    logic signed [Y_W-1:0]     y1_rd;
    logic signed [Y_W-1:0]     y2_rd;
    logic signed [SUM_W-1:0]   y1_ext;
    logic signed [SUM_W-1:0]   y1_abs;
    logic signed [SUM_W-1:0]   y_sum;
    logic signed [Y_W-1:0]     y_sat;
    logic signed [Y_W-1:0]     y1_next;
    logic signed [Y_W-1:0]     y2_next;
    logic                      trig;

    assign up_ready = !valid_reg || dn_ready;
    assign take     = s0_valid && up_ready;

    // Read channel state, apply reload, test for a wrap and step the map
    always_comb
    begin
        if (s0.reload)
        begin
            phase_rd = s0.neg ? '0 : PHASE_ONE;
            y1_rd    = init_y_prev;
            y2_rd    = init_y_prev2;
        end
        else
        begin
            phase_rd = phase_reg[s0.ch];
            y1_rd    = y1_reg[s0.ch];
            y2_rd    = y2_reg[s0.ch];
        end

        if (s0.neg)
        begin
            trig       = phase_rd <= 0;
            phase_wrap = trig ? phase_rd + PHASE_ONE : phase_rd;
        end
        else
        begin
            trig       = phase_rd >= PHASE_ONE;
            phase_wrap = trig ? phase_rd - PHASE_ONE : phase_rd;
        end
        phase_next = phase_wrap + {s0.step[STEP_W-1], s0.step};

        // y = 1 + |y1| - y2, saturated to Q8.24
        y1_ext = {{2{y1_rd[Y_W-1]}}, y1_rd};
        y1_abs = y1_rd[Y_W-1] ? -y1_ext : y1_ext;
        y_sum  = SUM_ONE + y1_abs - {{2{y2_rd[Y_W-1]}}, y2_rd};
        if (y_sum > SUM_MAX)
        begin
            y_sat = Y_W'(SUM_MAX);
        end
        else if (y_sum < SUM_MIN)
        begin
            y_sat = Y_W'(SUM_MIN);
        end
        else
        begin
            y_sat = y_sum[Y_W-1:0];
        end

        y1_next = trig ? y_sat : y1_rd;
        y2_next = trig ? y1_rd : y2_rd;

        data_next.ch   = s0.ch;
        data_next.trig = trig;
        data_next.y    = y1_next;
    end

    // Write back the channel state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                phase_reg[i] <= PHASE_ONE;
                y1_reg[i]    <= INIT_Y_PREV_RST;
                y2_reg[i]    <= INIT_Y_PREV2_RST;
            end
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg[s0.ch] <= phase_next;
                y1_reg[s0.ch]    <= y1_next;
                y2_reg[s0.ch]    <= y2_next;
            end
            if (up_ready)
            begin
                valid_reg <= s0_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1       = data_reg;

endmodule

// ----- sv/gco_scale.sv -----
// Output stages: scale the map value to a sample and hold the result item.
// Depends on gco_pkg.
module gco_scale
    import gco_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s1_valid,
    input  gco_s1_t               s1,
    output logic                  up_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            channel_out,
    output logic signed [Y_W-1:0] sample_out,
    output logic                  map_stepped
);

    localparam int SH_W = PROD_W - 32;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 62'sd2147483648;

    logic                       prod_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [CHAN_W-1:0]          prod_ch_reg;
    logic                       prod_trig_reg;
    logic signed [2*Y_W-1:0]    mul;

    logic                       out_valid_reg;
    logic signed [Y_W-1:0]      sample_reg;
    logic signed [Y_W-1:0]      sample_next;
    logic [CHAN_W-1:0]          ch_reg;
    logic                       trig_reg;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [SH_W-1:0]     shifted;
    logic                       out_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign up_ready  = !prod_valid_reg || out_ready;

    // Multiply by the gain
    assign mul = s1.y * GAIN_Q32;

    // Round to Q8.24 and remove the offset; the range cannot overflow 32 bits
    always_comb
    begin
        rounded     = prod_reg + ROUND_HALF;
        shifted     = rounded[PROD_W-1:32];
        sample_next = {{(Y_W-SH_W){shifted[SH_W-1]}}, shifted} - OFFSET_Q24;
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                prod_valid_reg <= s1_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && s1_valid)
        begin
            prod_reg      <= mul[PROD_W-1:0];
            prod_ch_reg   <= s1.ch;
            prod_trig_reg <= s1.trig;
        end
        if (out_ready && prod_valid_reg)
        begin
            sample_reg <= sample_next;
            ch_reg     <= prod_ch_reg;
            trig_reg   <= prod_trig_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = 3'(ch_reg);
    assign sample_out  = sample_reg;
    assign map_stepped = trig_reg;

endmodule

// ----- sv/gingerbread_chaos_oscillator.sv -----
// Top level of the gingerbread chaos oscillator: configuration registers and stages.
// Depends on gco_pkg, gco_step, gco_chan, gco_scale and the assertion header.
//
// Eight-channel chaotic oscillator. Each item is one sample tick for one channel and
// yields one result item through four registered stages: input register with the
// frequency-to-step multiply, channel state update, gain multiply, output register.
// Unless stalled, one item is accepted every cycle, including back-to-back ticks for
// the same channel, since the phase and map state of a channel is read, updated and
// written back in the same cycle. in_stall rises only once all four stages hold items
// and the output is stalled. Write configuration only while no item is in flight.

`include "gingerbread_chaos_oscillator_assert.svh"

module gingerbread_chaos_oscillator
    import gco_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               channel,
    input  logic signed [FREQ_W-1:0] frequency,
    input  logic                     reload,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               channel_out,
    output logic signed [Y_W-1:0]    sample_out,
    output logic                     map_stepped,
    input  logic                     wr_en,
    input  logic [1:0]               wr_index,
    input  logic [31:0]              wr_data
);

    localparam logic signed [Y_W-1:0] SAMPLE_LO = -32'sd398475657;
    localparam logic signed [Y_W-1:0] SAMPLE_HI = 32'sd383208391;

    logic [RATE_W-1:0]     rate_recip_reg;
    logic signed [Y_W-1:0] init_y_prev_reg;
    logic signed [Y_W-1:0] init_y_prev2_reg;

    logic    in_ready;
    logic    s0_valid;
    gco_s0_t s0;
    logic    chan_ready;
    logic    s1_valid;
    gco_s1_t s1;
    logic    scale_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_recip_reg   <= RATE_RECIP_RST;
            init_y_prev_reg  <= INIT_Y_PREV_RST;
            init_y_prev2_reg <= INIT_Y_PREV2_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_RATE_RECIP:   rate_recip_reg   <= wr_data;
                CFG_INIT_Y_PREV:  init_y_prev_reg  <= $signed(wr_data);
                CFG_INIT_Y_PREV2: init_y_prev2_reg <= $signed(wr_data);
                default:          ;
            endcase
        end
    end

    assign in_stall = !in_ready;

    gco_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .channel    (channel),
        .frequency  (frequency),
        .reload     (reload),
        .rate_recip (rate_recip_reg),
        .dn_ready   (chan_ready),
        .up_ready   (in_ready),
        .s0_valid   (s0_valid),
        .s0         (s0)
    );

    gco_chan u_chan (
        .clk          (clk),
        .rst_n        (rst_n),
        .s0_valid     (s0_valid),
        .s0           (s0),
        .init_y_prev  (init_y_prev_reg),
        .init_y_prev2 (init_y_prev2_reg),
        .dn_ready     (scale_ready),
        .up_ready     (chan_ready),
        .s1_valid     (s1_valid),
        .s1           (s1)
    );

    gco_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid),
        .s1          (s1),
        .up_ready    (scale_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_out (channel_out),
        .sample_out  (sample_out),
        .map_stepped (map_stepped)
    );

    // Input backs up only when every stage is full and the output is held
    `GCO_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, s0_valid && s1_valid && out_valid && out_stall)
    // An accepted tick always lands in the input stage
    `GCO_ASSERT_NXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, s0_valid)
    // Scaled sample stays inside the range reachable from any Q8.24 map value
    `GCO_ASSERT_IMP(a_sample_range, clk, rst_n, out_valid, sample_out >= SAMPLE_LO && sample_out <= SAMPLE_HI)

endmodule

// ----- verif/tb_gingerbread_chaos_oscillator.sv -----
// Testbench for gingerbread_chaos_oscillator: tick stimulus, register writes and
// an in-order scoreboard fed by a cycle-free model of the oscillator channels.
// Depends on gco_pkg and the RTL of the block only.
module tb_gingerbread_chaos_oscillator;
    import gco_pkg::*;

    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [1:0]  CFG_UNUSED_IDX = 2'd3;
    localparam longint      Q24_MAX        = 64'sd2147483647;
    localparam longint      Q24_MIN        = -64'sd2147483648;
    localparam longint      MAP_ONE        = 64'sd1 << 24;

    typedef struct {
        logic [2:0]            chan;
        logic signed [Y_W-1:0] sample;
        logic                  stepped;
    } osc_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [2:0]               channel;
    logic signed [FREQ_W-1:0] frequency;
    logic                     reload;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [2:0]               channel_out;
    logic signed [Y_W-1:0]    sample_out;
    logic                     map_stepped;
    logic                     wr_en;
    logic [1:0]               wr_index;
    logic [31:0]              wr_data;

    // Model state: register copies and per-channel oscillator state
    logic [31:0]           cfg_rate;
    logic signed [Y_W-1:0] cfg_seed_last;
    logic signed [Y_W-1:0] cfg_seed_older;
    longint                osc_phase [8];
    logic signed [Y_W-1:0] map_last [8];
    logic signed [Y_W-1:0] map_older [8];

    osc_result_t pending_samples [$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    gingerbread_chaos_oscillator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .channel     (channel),
        .frequency   (frequency),
        .reload      (reload),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_out (channel_out),
        .sample_out  (sample_out),
        .map_stepped (map_stepped),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [Y_W-1:0] clip_q24(input longint v);
        if (v > Q24_MAX)
            return Q24_MAX[31:0];
        if (v < Q24_MIN)
            return Q24_MIN[31:0];
        return v[31:0];
    endfunction

    // Advance one channel by one sample tick and queue the sample it yields
    function automatic void predict_tick(input logic [2:0] ch,
                                         input logic signed [FREQ_W-1:0] hz,
                                         input logic rl);
        longint      f;
        longint      step;
        longint      mag;
        longint      acc;
        osc_result_t r;
        f = longint'(hz);
        if (rl)
        begin
            osc_phase[ch] = (f >= 0) ? longint'(PHASE_ONE) : 64'sd0;
            map_last[ch]  = cfg_seed_last;
            map_older[ch] = cfg_seed_older;
        end
        step = f * longint'(cfg_rate);
        if (step > longint'(PHASE_ONE))
            step = longint'(PHASE_ONE);
        if (step < -longint'(PHASE_ONE))
            step = -longint'(PHASE_ONE);
        // wrap test comes before the step is added
        if (f >= 0)
        begin
            r.stepped = (osc_phase[ch] >= longint'(PHASE_ONE));
            if (r.stepped)
                osc_phase[ch] -= longint'(PHASE_ONE);
        end
        else
        begin
            r.stepped = (osc_phase[ch] <= 0);
            if (r.stepped)
                osc_phase[ch] += longint'(PHASE_ONE);
        end
        // gingerbreadman step: y = 1 + |y1| - y2, saturated
        if (r.stepped)
        begin
            mag = longint'(map_last[ch]);
            if (mag < 0)
                mag = -mag;
            acc = MAP_ONE + mag - longint'(map_older[ch]);
            map_older[ch] = map_last[ch];
            map_last[ch]  = clip_q24(acc);
        end
        // scale by 0.182 with round half up, then remove the 0.455 offset
        acc = longint'(map_last[ch]) * longint'(GAIN_Q32) + (64'sd1 << 31);
        acc = (acc >>> 32) - longint'(OFFSET_Q24);
        r.sample = clip_q24(acc);
        r.chan   = ch;
        osc_phase[ch] += step;
        pending_samples.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        fail_count++;
        if (fail_count <= 40)
            $display("ERROR at %0t: %s, expected %0d, got %0d", $time, what, want, got);
    endtask

    // Offer one item, idling at random first; return once it is accepted
    task automatic send_tick(input logic [2:0] ch, input logic signed [FREQ_W-1:0] hz,
                             input logic rl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        channel   <= ch;
        frequency <= hz;
        reload    <= rl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tick(ch, hz, rl);
    endtask

    // Drain the pipeline, then write one register
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_RATE_RECIP:   cfg_rate = value;
            CFG_INIT_Y_PREV:  cfg_seed_last = value;
            CFG_INIT_Y_PREV2: cfg_seed_older = value;
            default: ;
        endcase
    endtask

    // Reset state: zero, top and bottom frequencies on untouched channels
    task automatic test_reset_state();
        send_tick(3'd0, 19'sd0, 1'b0);
        send_tick(3'd7, 19'sd192000, 1'b0);
        send_tick(3'd3, -19'sd192000, 1'b0);
        send_tick(3'd5, 19'sd262143, 1'b0);
        send_tick(3'd6, -19'sd262144, 1'b0);
    endtask

    // Reload sets phase by direction; smallest steps both ways
    task automatic test_reload_direction();
        send_tick(3'd1, -19'sd1, 1'b1);
        send_tick(3'd1, -19'sd1, 1'b0);
        send_tick(3'd2, 19'sd1, 1'b1);
        send_tick(3'd2, 19'sd0, 1'b0);
    endtask

    // Step of exactly one period: phase lands on the wrap boundary every tick
    task automatic test_exact_wrap();
        write_register(CFG_RATE_RECIP, 32'h0100_0000);
        send_tick(3'd4, 19'sd256, 1'b1);
        send_tick(3'd4, 19'sd256, 1'b0);
        send_tick(3'd4, -19'sd256, 1'b1);
        send_tick(3'd4, -19'sd256, 1'b0);
    endtask

    // Register extremes: largest and zero rate, seeds at both ends of Q8.24
    task automatic test_register_extremes();
        write_register(CFG_RATE_RECIP, 32'hFFFF_FFFF);
        write_register(CFG_INIT_Y_PREV, 32'h7FFF_FFFF);
        write_register(CFG_INIT_Y_PREV2, 32'h8000_0000);
        send_tick(3'd0, 19'sd1, 1'b1);
        send_tick(3'd0, -19'sd1, 1'b0);
        send_tick(3'd0, 19'sd1, 1'b0);
        write_register(CFG_INIT_Y_PREV, 32'h8000_0000);
        write_register(CFG_INIT_Y_PREV2, 32'h7FFF_FFFF);
        send_tick(3'd1, 19'sd262143, 1'b1);
        send_tick(3'd1, 19'sd262143, 1'b0);
        write_register(CFG_RATE_RECIP, 32'd0);
        send_tick(3'd2, -19'sd262144, 1'b1);
        send_tick(3'd2, -19'sd262144, 1'b0);
    endtask

    // A write to the unused index must leave every register alone
    task automatic test_unused_register();
        write_register(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        send_tick(3'd3, 19'sd5, 1'b1);
    endtask

    // Random tones on random channels with random registers, plus stray ticks
    task automatic test_random_ticks(input int count);
        int                       sent;
        int                       run;
        int                       k;
        logic [2:0]               ch;
        logic signed [FREQ_W-1:0] hz;
        logic [31:0]              rate;
        sent = 0;
        case ($urandom_range(3))
            0:       rate = 32'd89478;
            1:       rate = 32'd97391;
            2:       rate = $urandom_range(2000000);
            default: rate = $urandom;
        endcase
        write_register(CFG_RATE_RECIP, rate);
        write_register(CFG_INIT_Y_PREV,
                       $urandom_range(1) ? $urandom : $urandom_range(50331648));
        write_register(CFG_INIT_Y_PREV2,
                       $urandom_range(1) ? $urandom : $urandom_range(50331648));
        while (sent < count)
        begin
            ch = 3'($urandom);
            if ($urandom_range(9) < 8)
            begin
                // steady tone: one channel, one frequency, optional reload up front
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: hz = FREQ_W'($urandom_range(24000));
                    6, 7:             hz = FREQ_W'($urandom_range(192000));
                    8:                hz = FREQ_W'($urandom);
                    default:          hz = $urandom_range(1) ? 19'sd262143 : 19'sd192000;
                endcase
                if ($urandom_range(1))
                    hz = -hz;
                run = $urandom_range(24, 1);
                for (k = 0; k < run; k++)
                begin
                    send_tick(ch, hz, (k == 0) && ($urandom_range(3) == 0));
                    sent++;
                end
            end
            else
            begin
                hz = FREQ_W'($urandom);
                send_tick(ch, hz, 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // Retire result items in order and drive the output stall
    always @(posedge clk)
    begin : check_results
        osc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
                report_mismatch("result item with no tick pending, channel_out", -1,
                                channel_out);
            else
            begin
                want = pending_samples.pop_front();
                if (channel_out !== want.chan)
                    report_mismatch("channel_out", want.chan, channel_out);
                if (sample_out !== want.sample)
                    report_mismatch("sample_out", want.sample, sample_out);
                if (map_stepped !== want.stepped)
                    report_mismatch("map_stepped", want.stepped, map_stepped);
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        channel   <= 3'd0;
        frequency <= '0;
        reload    <= 1'b0;
        wr_en     <= 1'b0;
        wr_index  <= 2'd0;
        wr_data   <= 32'd0;
        cfg_rate       = RATE_RECIP_RST;
        cfg_seed_last  = INIT_Y_PREV_RST;
        cfg_seed_older = INIT_Y_PREV2_RST;
        for (int c = 0; c < 8; c++)
        begin
            osc_phase[c] = longint'(PHASE_ONE);
            map_last[c]  = INIT_Y_PREV_RST;
            map_older[c] = INIT_Y_PREV2_RST;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 86;
        test_reset_state();
        test_reload_direction();
        test_exact_wrap();
        test_register_extremes();
        test_unused_register();
        test_random_ticks(410);
        send_idle_pct = 86;
        recv_idle_pct = 27;
        test_random_ticks(410);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ticks(410);

        // Hold off until every result item is back, then let the pipe settle
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Bound the run in case the block hangs
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- gingerbread_chaos_oscillator.f -----
+incdir+sv
sv/gco_pkg.sv
sv/gco_step.sv
sv/gco_chan.sv
sv/gco_scale.sv
sv/gingerbread_chaos_oscillator.sv
verif/tb_gingerbread_chaos_oscillator.sv
